### src/bbs3_pkg.sv
// Package for the binary 3x3 binomial smoothing filter.
// Holds sizes, register indexes, the stage record and the kernel weight function.
// No dependencies.
`default_nettype none

package bbs3_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;

   localparam int DIM_W = 11;
   localparam int THR_W = 5;
   localparam int PIX_W = 8;
   localparam int SUM_W = 5;
   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int ROW_W = $clog2(MAX_HEIGHT + 2);
   localparam int POS_W = $clog2(MAX_WIDTH * MAX_HEIGHT);
   localparam int IDX_W = 2;

   localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
   localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
   localparam logic [IDX_W-1:0] REG_ON_THRESHOLD = 2'd2;

   localparam logic [DIM_W-1:0] WIDTH_RESET     = 11'd1024;
   localparam logic [DIM_W-1:0] HEIGHT_RESET    = 11'd1024;
   localparam logic [THR_W-1:0] THRESHOLD_RESET = 5'd8;

   localparam logic [PIX_W-1:0] PIX_ON  = 8'd255;
   localparam logic [PIX_W-1:0] PIX_OFF = 8'd0;

   // word state carried from the counter stage to the line-store stage
   typedef struct packed {
      logic [COL_W-1:0] addr;
      logic             bot;
      logic             has_mid;
      logic             has_top;
      logic             first_col;
      logic             emit;
      logic             last;
   } stage_type;

   // column of 3 bits: bit0 top, bit1 middle, bit2 bottom; weights 1 2 1
   function automatic logic [SUM_W-1:0] side_weight(input logic [2:0] col);
      side_weight = SUM_W'(col[0]) + SUM_W'({col[1], 1'b0}) + SUM_W'(col[2]);
   endfunction

endpackage

`default_nettype wire

### src/binary_binomial_smoothing_3x3.sv
// Binary 3x3 binomial smoothing filter, top level.
// Uses bbs3_pkg. An input word is registered in the line-store stage, its result then
// in the output register; an output row lags the input by one row plus one pixel.
// Throughput: one word per cycle unless a held output stalls, set by the single read
// and write per word on the line store. Reset clears config, counters, window and
// valid flags; the line store is not cleared, the row counter masks it until written.
`default_nettype none

module binary_binomial_smoothing_3x3 (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           req_tvalid,
   output logic                          req_tready,
   input  wire  [bbs3_pkg::PIX_W-1:0]    req_tdata,   // pixel
   input  wire                           req_tuser,   // kind (1 = flush)
   output logic                          rsp_tvalid,
   input  wire                           rsp_tready,
   output logic [bbs3_pkg::PIX_W-1:0]    rsp_tdata,   // filtered_pixel
   output logic                          rsp_tlast,   // last_of_frame
   input  wire                           csr_we,
   input  wire  [bbs3_pkg::IDX_W-1:0]    csr_index,
   input  wire  [bbs3_pkg::DIM_W-1:0]    csr_wdata
);

   localparam int COL_W = bbs3_pkg::COL_W;
   localparam int ROW_W = bbs3_pkg::ROW_W;
   localparam int POS_W = bbs3_pkg::POS_W;
   localparam int DIM_W = bbs3_pkg::DIM_W;
   localparam int THR_W = bbs3_pkg::THR_W;
   localparam int SUM_W = bbs3_pkg::SUM_W;

   // configuration
   logic [DIM_W-1:0] width_ff, width_in;
   logic [DIM_W-1:0] height_ff, height_in;
   logic [THR_W-1:0] thresh_ff, thresh_in;
   logic             restart;

   // counters
   logic [COL_W-1:0] in_col_ff, in_col_in;
   logic [ROW_W-1:0] in_row_ff, in_row_in;
   logic [POS_W-1:0] out_pos_ff, out_pos_in;

   // line-store stage
   logic                s1_valid_ff, s1_valid_in;
   bbs3_pkg::stage_type s1_ff, s1_in;
   logic                fwd_ff, fwd_in;
   logic [1:0]          fwd_data_ff;
   logic [1:0]          line_rd_ff;
   logic [1:0]          line_mem [bbs3_pkg::MAX_WIDTH];
   logic [8:0]          window_ff, window_in;

   // output register
   logic                       out_valid_ff, out_valid_in;
   logic [bbs3_pkg::PIX_W-1:0] out_pix_ff, out_pix_in;
   logic                       out_last_ff, out_last_in;

   logic             advance, accept, take;
   logic [DIM_W-1:0] eff_w, eff_h;
   logic [2*DIM_W-1:0] area;
   logic             flush, in_frame, emit0, last0, row_end;
   logic             mid, top;
   logic [2:0]       col;
   logic [8:0]       win;
   logic [SUM_W-1:0] sum;
   logic [1:0]       wr_data;

   // ---------------- configuration ----------------
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      thresh_in = thresh_ff;
      restart   = 1'b0;
      if (csr_we) begin
         unique case (csr_index)
            bbs3_pkg::REG_FRAME_WIDTH: begin
               width_in = csr_wdata;
               restart  = 1'b1;
            end
            bbs3_pkg::REG_FRAME_HEIGHT: begin
               height_in = csr_wdata;
               restart   = 1'b1;
            end
            bbs3_pkg::REG_ON_THRESHOLD: begin
               thresh_in = csr_wdata[THR_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      if (width_ff == '0) begin
         eff_w = DIM_W'(1);
      end else if (32'(width_ff) > bbs3_pkg::MAX_WIDTH) begin
         eff_w = DIM_W'(bbs3_pkg::MAX_WIDTH);
      end else begin
         eff_w = width_ff;
      end
      if (height_ff == '0) begin
         eff_h = DIM_W'(1);
      end else if (32'(height_ff) > bbs3_pkg::MAX_HEIGHT) begin
         eff_h = DIM_W'(bbs3_pkg::MAX_HEIGHT);
      end else begin
         eff_h = height_ff;
      end
      area = (2*DIM_W)'(eff_w) * (2*DIM_W)'(eff_h);
   end

   // ---------------- handshake ----------------
   assign advance    = !(s1_valid_ff && s1_ff.emit && out_valid_ff && !rsp_tready);
   assign req_tready = advance;
   assign accept     = req_tvalid && advance;

   // ---------------- counter stage ----------------
   always_comb begin
      flush    = req_tuser;
      in_frame = 32'(in_row_ff) < 32'(eff_h);
      take     = accept && !(flush && in_frame);
      emit0    = (32'(in_row_ff) >= 2) || ((32'(in_row_ff) == 1) && (in_col_ff != '0));
      last0    = emit0 && ((32'(out_pos_ff) + 32'd1) >= 32'(area));
      row_end  = (32'(in_col_ff) + 32'd1) >= 32'(eff_w);

      s1_in.addr      = in_col_ff;
      s1_in.bot       = in_frame && !flush && (req_tdata != '0);
      s1_in.has_mid   = 32'(in_row_ff) >= 1;
      s1_in.has_top   = 32'(in_row_ff) >= 2;
      s1_in.first_col = in_col_ff == '0;
      s1_in.emit      = emit0;
      s1_in.last      = last0;

      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_pos_in = out_pos_ff;
      if (restart) begin
         in_col_in  = '0;
         in_row_in  = '0;
         out_pos_in = '0;
      end else if (take) begin
         if (last0) begin
            in_col_in  = '0;
            in_row_in  = '0;
            out_pos_in = '0;
         end else begin
            if (row_end) begin
               in_col_in = '0;
               in_row_in = ROW_W'(32'(in_row_ff) + 32'd1);
            end else begin
               in_col_in = COL_W'(32'(in_col_ff) + 32'd1);
            end
            if (emit0) begin
               out_pos_in = POS_W'(32'(out_pos_ff) + 32'd1);
            end
         end
      end

      s1_valid_in = advance ? take : s1_valid_ff;
      fwd_in      = s1_valid_ff && (s1_ff.addr == in_col_ff);
   end

   // ---------------- line-store stage ----------------
   always_comb begin
      mid = s1_ff.has_mid && (fwd_ff ? fwd_data_ff[0] : line_rd_ff[0]);
      top = s1_ff.has_top && (fwd_ff ? fwd_data_ff[1] : line_rd_ff[1]);
      col = {s1_ff.bot, mid, top};
      wr_data = {mid, s1_ff.bot};   // bit1 upper row, bit0 middle row

      if (s1_ff.first_col) begin
         win       = {3'b000, window_ff[8:3]};
         window_in = {col, 6'b000000};
      end else begin
         win       = {col, window_ff[8:3]};
         window_in = win;
      end
      if (restart) begin
         window_in = '0;
      end else if (!(advance && s1_valid_ff)) begin
         window_in = window_ff;
      end

      sum = bbs3_pkg::side_weight(win[2:0])
          + SUM_W'({bbs3_pkg::side_weight(win[5:3]), 1'b0})
          + bbs3_pkg::side_weight(win[8:6]);

      out_valid_in = out_valid_ff && !rsp_tready;
      out_pix_in   = out_pix_ff;
      out_last_in  = out_last_ff;
      if (advance && s1_valid_ff && s1_ff.emit) begin
         out_valid_in = 1'b1;
         out_pix_in   = (sum >= thresh_ff) ? bbs3_pkg::PIX_ON : bbs3_pkg::PIX_OFF;
         out_last_in  = s1_ff.last;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && s1_valid_ff) begin
         line_mem[s1_ff.addr] <= wr_data;
      end
      if (advance) begin
         line_rd_ff  <= line_mem[in_col_ff];
         s1_ff       <= s1_in;
         fwd_ff      <= fwd_in;
         fwd_data_ff <= wr_data;
      end
      out_pix_ff  <= out_pix_in;
      out_last_ff <= out_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= bbs3_pkg::WIDTH_RESET;
         height_ff    <= bbs3_pkg::HEIGHT_RESET;
         thresh_ff    <= bbs3_pkg::THRESHOLD_RESET;
         in_col_ff    <= '0;
         in_row_ff    <= '0;
         out_pos_ff   <= '0;
         s1_valid_ff  <= 1'b0;
         window_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         width_ff     <= width_in;
         height_ff    <= height_in;
         thresh_ff    <= thresh_in;
         in_col_ff    <= in_col_in;
         in_row_ff    <= in_row_in;
         out_pos_ff   <= out_pos_in;
         s1_valid_ff  <= s1_valid_in;
         window_ff    <= window_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_pix_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

`default_nettype wire
